// File: hdl/rwcp_pkg.sv
// ----------------------------------------------------------------------------
// rwcp_pkg
// shared types, constants and cosine table helper for the wall column projection
// ----------------------------------------------------------------------------
package rwcp_pkg;

    localparam int COS_TABLE_DEPTH_DEF = 1024;

    // pi/2 in Q16 and Q30
    localparam longint unsigned HALF_PI_Q16 = 64'd102944;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1 << 30;

    // reciprocal of pi/2 (Q16) for the angle-to-index scaling
    localparam int              RECIP_SHIFT = 48;
    localparam longint unsigned RECIP_FULL  =
        ((64'd1 << RECIP_SHIFT) + HALF_PI_Q16 - 64'd1) / HALF_PI_Q16;
    localparam logic [31:0]     RECIP_Q48   = RECIP_FULL[31:0];

    localparam int DIV_BITS = 24;
    localparam int DEN_W    = 52;

    localparam logic [23:0] HEIGHT_MAX = 24'hFFFFFF;

    // register indexes
    localparam logic [7:0] REG_WINDOW_WIDTH  = 8'd0;
    localparam logic [7:0] REG_WINDOW_HEIGHT = 8'd1;
    localparam logic [7:0] REG_VIEW_SCALE    = 8'd2;
    localparam logic [7:0] REG_MIN_DISTANCE  = 8'd3;

    localparam logic [11:0] WINDOW_WIDTH_RST  = 12'd640;
    localparam logic [11:0] WINDOW_HEIGHT_RST = 12'd480;
    localparam logic [23:0] VIEW_SCALE_RST    = 24'd65536;
    localparam logic [15:0] MIN_DISTANCE_RST  = 16'd66;

    typedef struct packed {
        logic [27:0]        ray_distance;
        logic signed [15:0] angle_offset;
    } in_beat_t;

    typedef struct packed {
        logic [23:0]        slice_height;
        logic signed [23:0] wall_top;
        logic [11:0]        draw_start;
        logic [11:0]        draw_end;
    } out_beat_t;

    // one lane of the restoring divider chain
    typedef struct packed {
        logic                 valid;
        logic                 sat;
        logic [DEN_W-1:0]     rem;
        logic [DEN_W-1:0]     den;
        logic [DIV_BITS-1:0]  quo;
    } div_lane_t;

    // cosine of angle x (Q30) by Taylor series to x^16, rounded to Q1.15
    function automatic logic [15:0] cos_taylor(input longint unsigned x);
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint unsigned r;
        x2   = (x * x) >> 30;
        term = ONE_Q30;
        sum  = longint'(ONE_Q30);
        term = ((term * x2) >> 30) / 2;   sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 12;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 30;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 56;  sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 90;  sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 132; sum = sum + longint'(term);
        term = ((term * x2) >> 30) / 182; sum = sum - longint'(term);
        term = ((term * x2) >> 30) / 240; sum = sum + longint'(term);
        if (sum < 0) begin
            sum = 0;
        end
        r = (longint'(sum) + 64'd16384) >> 15;
        if (r > 64'd32768) begin
            r = 64'd32768;
        end
        return r[15:0];
    endfunction

endpackage

// File: hdl/rwcp_cos_rom.sv
// ----------------------------------------------------------------------------
// rwcp_cos_rom
// quarter-wave cosine table in Q1.15, registered read
// ----------------------------------------------------------------------------
module rwcp_cos_rom import rwcp_pkg::*; #(
    parameter int DEPTH = COS_TABLE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [$clog2(DEPTH+1)-1:0] addr,
    output logic [15:0]                data
);

    logic [15:0] rom [0:DEPTH];
    logic [15:0] data_reg;

    for (genvar g = 0; g <= DEPTH; g++) begin : g_entry
        localparam longint unsigned X =
            (longint'(g) * HALF_PI_Q30 + longint'(DEPTH / 2)) / longint'(DEPTH);
        assign rom[g] = cos_taylor(X);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg <= rom[addr];
        end
    end

    assign data = data_reg;

endmodule

// File: hdl/rwcp_div_cell.sv
// ----------------------------------------------------------------------------
// rwcp_div_cell
// one restoring divide step, one quotient bit per cell
// ----------------------------------------------------------------------------
module rwcp_div_cell import rwcp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  div_lane_t lane_in,
    output div_lane_t lane_out
);

    logic [DEN_W:0]   rem_dbl;
    logic             take;
    logic [DEN_W:0]   rem_sub;
    logic             valid_reg;
    logic             sat_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [DIV_BITS-1:0] quo_reg;

    assign rem_dbl = {lane_in.rem, 1'b0};
    assign take    = rem_dbl >= {1'b0, lane_in.den};
    assign rem_sub = rem_dbl - {1'b0, lane_in.den};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= lane_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sat_reg <= lane_in.sat;
            den_reg <= lane_in.den;
            rem_reg <= take ? rem_sub[DEN_W-1:0] : rem_dbl[DEN_W-1:0];
            quo_reg <= {lane_in.quo[DIV_BITS-2:0], take};
        end
    end

    assign lane_out = '{valid: valid_reg, sat: sat_reg, rem: rem_reg,
                        den: den_reg, quo: quo_reg};

endmodule

// File: hdl/raycast_wall_column_projection_core.sv
// ----------------------------------------------------------------------------
// raycast_wall_column_projection_core
// fisheye-corrected wall slice height, top row and drawn row range per column
// ----------------------------------------------------------------------------
// pipeline: 7 front stages, 24 cells and an output register between input beat
//   and result beat
// throughput: one beat per cycle, set by the single-bit divider cell chain
// a stall on the result side holds the whole pipeline
// reset: synchronous active-low aresetn clears all valid bits and loads the
//   register defaults (640, 480, 1.0, 66)
// ----------------------------------------------------------------------------
module raycast_wall_column_projection_core import rwcp_pkg::*; #(
    parameter int COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [23:0] cfg_data,
    // ray beats in
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    // result beats out
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data
);

    localparam int IDX_W = $clog2(COS_TABLE_DEPTH + 1);
    localparam int PW    = $clog2(4 * COS_TABLE_DEPTH);
    localparam int NW    = 17 + $clog2(8 * COS_TABLE_DEPTH);
    localparam int PRW   = NW + 32;

    localparam logic [NW-1:0]    N_SCALE  = NW'(8 * COS_TABLE_DEPTH);
    localparam logic [NW-1:0]    N_ROUND  = NW'(HALF_PI_Q16 / 2);
    localparam logic [PW-1:0]    P_D1     = PW'(COS_TABLE_DEPTH);
    localparam logic [PW-1:0]    P_D2     = PW'(2 * COS_TABLE_DEPTH);
    localparam logic [PW-1:0]    P_D3     = PW'(3 * COS_TABLE_DEPTH);
    localparam logic [IDX_W-1:0] IDX_FULL = IDX_W'(COS_TABLE_DEPTH);

    // configuration registers
    logic [11:0] window_width_reg;
    logic [11:0] window_height_reg;
    logic [23:0] view_scale_reg;
    logic [15:0] min_distance_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_width_reg  <= WINDOW_WIDTH_RST;
            window_height_reg <= WINDOW_HEIGHT_RST;
            view_scale_reg    <= VIEW_SCALE_RST;
            min_distance_reg  <= MIN_DISTANCE_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_WINDOW_WIDTH:  window_width_reg  <= cfg_data[11:0];
                REG_WINDOW_HEIGHT: window_height_reg <= cfg_data[11:0];
                REG_VIEW_SCALE:    view_scale_reg    <= cfg_data;
                REG_MIN_DISTANCE:  min_distance_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves when the output register is free or being drained
    logic en;
    logic m_valid_reg;
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // stage valid bits for the front stages
    logic [6:0] vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:0], s_valid};
        end
    end

    // stage 1: |angle| scaled to table steps, times reciprocal of pi/2
    logic [15:0]    mag;
    logic [NW-1:0]  num;
    logic [27:0]    ray1_reg;
    logic [PRW-1:0] prod1_reg;

    assign mag = s_data.angle_offset[15] ? 16'(-s_data.angle_offset)
                                         : 16'(s_data.angle_offset);
    assign num = NW'(mag) * N_SCALE + N_ROUND;

    always_ff @(posedge aclk) begin
        if (en) begin
            ray1_reg  <= s_data.ray_distance;
            prod1_reg <= PRW'(num) * PRW'(RECIP_Q48);
        end
    end

    // stage 2: quadrant and table address
    logic [PW-1:0]    pidx;
    logic [1:0]       quad;
    logic [PW-1:0]    rem_p;
    logic [IDX_W-1:0] rem_i;
    logic [IDX_W-1:0] addr2_reg;
    logic             neg2_reg;
    logic [27:0]      ray2_reg;

    assign pidx = prod1_reg[RECIP_SHIFT +: PW];

    always_comb begin
        if (pidx < P_D1) begin
            quad  = 2'd0;
            rem_p = pidx;
        end else if (pidx < P_D2) begin
            quad  = 2'd1;
            rem_p = pidx - P_D1;
        end else if (pidx < P_D3) begin
            quad  = 2'd2;
            rem_p = pidx - P_D2;
        end else begin
            quad  = 2'd3;
            rem_p = pidx - P_D3;
        end
        rem_i = rem_p[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            addr2_reg <= quad[0] ? (IDX_FULL - rem_i) : rem_i;
            neg2_reg  <= (quad == 2'd1) || (quad == 2'd2);
            ray2_reg  <= ray1_reg;
        end
    end

    // stage 3: table read
    logic [15:0] cos3;
    logic        neg3_reg;
    logic [27:0] ray3_reg;

    rwcp_cos_rom #(
        .DEPTH (COS_TABLE_DEPTH)
    ) u_cos_rom (
        .aclk (aclk),
        .en   (en),
        .addr (addr2_reg),
        .data (cos3)
    );

    always_ff @(posedge aclk) begin
        if (en) begin
            neg3_reg <= neg2_reg;
            ray3_reg <= ray2_reg;
        end
    end

    // stage 4: fisheye correction, zero when cosine is not positive
    logic [43:0] corr;
    logic [27:0] dist4_reg;

    assign corr = 44'(ray3_reg) * 44'(cos3);

    always_ff @(posedge aclk) begin
        if (en) begin
            dist4_reg <= (!neg3_reg && (cos3 != 16'd0)) ? corr[42:15] : 28'd0;
        end
    end

    // stage 5: distance floor
    logic [27:0] dist5_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dist5_reg <= (dist4_reg < 28'(min_distance_reg)) ? 28'(min_distance_reg)
                                                             : dist4_reg;
        end
    end

    // stage 6: divisor = scale * distance
    logic [DEN_W-1:0] den6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            den6_reg <= DEN_W'(view_scale_reg) * DEN_W'(dist5_reg);
        end
    end

    // stage 7 feeds the cell chain; width << 39 has 24 zero low bits, so the
    // partial remainder starts at width << 15 and shifts in zeros
    logic [DEN_W-1:0] num_hi;
    logic             sat0_reg;
    logic [DEN_W-1:0] rem0_reg;
    logic [DEN_W-1:0] den0_reg;
    div_lane_t        lane [0:DIV_BITS];

    assign num_hi = DEN_W'({window_width_reg, 15'd0});

    always_ff @(posedge aclk) begin
        if (en) begin
            sat0_reg <= num_hi >= den6_reg;
            rem0_reg <= num_hi;
            den0_reg <= den6_reg;
        end
    end

    assign lane[0] = '{valid: vld_reg[6], sat: sat0_reg, rem: rem0_reg,
                       den: den0_reg, quo: {DIV_BITS{1'b0}}};

    for (genvar c = 0; c < DIV_BITS; c++) begin : g_cell
        rwcp_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .lane_in  (lane[c]),
            .lane_out (lane[c+1])
        );
    end

    // output stage: saturate, wall top, row range
    logic [23:0]        height;
    logic [19:0]        hq;
    logic signed [25:0] t2;
    logic signed [25:0] top;
    logic signed [25:0] bottom;
    out_beat_t          m_data_reg;

    assign height = lane[DIV_BITS].sat ? HEIGHT_MAX : lane[DIV_BITS].quo;
    assign hq     = {window_height_reg, 8'd0};
    assign t2     = $signed({6'd0, hq}) - $signed({2'd0, height});
    assign top    = t2 >>> 1;
    assign bottom = top + $signed({2'd0, height});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= lane[DIV_BITS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.slice_height <= height;
            m_data_reg.wall_top     <= top[23:0];
            m_data_reg.draw_start   <= top[25] ? 12'd0 : top[19:8];
            m_data_reg.draw_end     <= (bottom > $signed({6'd0, hq})) ? window_height_reg
                                                                      : bottom[19:8];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
